// File: hw/rtl/dbgbp_pkg.sv
// ----------------------------------------------------------------------------
// dbgbp_pkg
// shared types and constants of the breakpoint and run-control unit
// ----------------------------------------------------------------------------
package dbgbp_pkg;

    localparam int BREAKPOINT_SLOTS = 16;
    localparam int SLOT_W   = (BREAKPOINT_SLOTS > 1) ? $clog2(BREAKPOINT_SLOTS) : 1;
    localparam int SLOT_LOG = $clog2(BREAKPOINT_SLOTS);
    localparam int SLOT_POW = 1 << SLOT_LOG;
    localparam int CNT_W    = (SLOT_LOG > 1) ? $clog2(SLOT_LOG) : 1;

    localparam logic [3:0] CMD_SET       = 4'd0;
    localparam logic [3:0] CMD_REMOVE    = 4'd1;
    localparam logic [3:0] CMD_RUN       = 4'd2;
    localparam logic [3:0] CMD_RUN_FOR   = 4'd3;
    localparam logic [3:0] CMD_STEP_OVER = 4'd4;
    localparam logic [3:0] CMD_STEP_OUT  = 4'd5;
    localparam logic [3:0] CMD_PRE_INSTR = 4'd6;
    localparam logic [3:0] CMD_POST_INSTR = 4'd7;
    localparam logic [3:0] CMD_SUB_ENTER = 4'd8;
    localparam logic [3:0] CMD_SUB_EXIT  = 4'd9;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [15:0] address;
        logic [15:0] bp_id;
        logic [31:0] count;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        logic [15:0] hit_id;
        logic        stop;
        logic [15:0] new_id;
        logic        found;
        logic        full_res;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic load;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_pre;
    } t_ctl_status;

endpackage

// File: hw/rtl/dbgbp_ctrl.sv
// ----------------------------------------------------------------------------
// dbgbp_ctrl
// sequencer: takes an item, waits out the lookup tree for pre-instruction items, loads the result
// ----------------------------------------------------------------------------
module dbgbp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    input  dbgbp_pkg::t_ctl_status i_status,
    output dbgbp_pkg::t_ctl_cmd   o_cmd
);
    import dbgbp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_SEARCH = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic             load;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.is_pre) begin
                    if (SLOT_LOG == 0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SEARCH;
                        n_cnt   = CNT_W'(SLOT_LOG - 1);
                    end
                end else if (out_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SEARCH: begin
                // one tree level per cycle
                if (r_cnt == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.load    = load;

endmodule

// File: hw/rtl/dbgbp_dp.sv
// ----------------------------------------------------------------------------
// dbgbp_dp
// breakpoint slots, lowest-id lookup tree and run-control counters
// ----------------------------------------------------------------------------
module dbgbp_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dbgbp_pkg::t_in_item    i_in_item,
    output dbgbp_pkg::t_out_item   o_out_item,
    input  dbgbp_pkg::t_ctl_cmd    i_cmd,
    output dbgbp_pkg::t_ctl_status o_status
);
    import dbgbp_pkg::*;

    t_in_item  r_item;
    t_out_item r_out, n_out;

    logic [BREAKPOINT_SLOTS-1:0] r_slot_valid;
    logic [15:0]                 r_slot_addr  [BREAKPOINT_SLOTS];
    logic [15:0]                 r_slot_ident [BREAKPOINT_SLOTS];

    logic [15:0] r_next_ident;
    logic [31:0] r_exec_cnt, n_exec_cnt;
    logic [31:0] r_target,   n_target;
    logic        r_limited,  n_limited;
    logic [15:0] r_depth,    n_depth;

    logic              free_ok, rm_ok;
    logic [SLOT_W-1:0] free_idx, rm_idx;
    logic [31:0]       exec_inc;

    // lookup tree: level 0 holds per-slot matches, the last level one winner
    logic        r_tv  [SLOT_LOG+1][SLOT_POW];
    logic [15:0] r_tid [SLOT_LOG+1][SLOT_POW];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
        end
    end

    // lowest free slot and lowest slot holding the id to remove
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        rm_ok    = 1'b0;
        rm_idx   = '0;
        for (int i = 0; i < BREAKPOINT_SLOTS; i++) begin
            if (!free_ok && !r_slot_valid[i]) begin
                free_ok  = 1'b1;
                free_idx = SLOT_W'(i);
            end
            if (!rm_ok && r_slot_valid[i] && r_slot_ident[i] == r_item.bp_id) begin
                rm_ok  = 1'b1;
                rm_idx = SLOT_W'(i);
            end
        end
    end

    genvar gj, gl;
    generate
        for (gj = 0; gj < SLOT_POW; gj++) begin : g_leaf
            if (gj < BREAKPOINT_SLOTS) begin : g_real
                always_ff @(posedge i_clk) begin
                    r_tv[0][gj]  <= r_slot_valid[gj] && (r_slot_addr[gj] == r_item.address);
                    r_tid[0][gj] <= r_slot_ident[gj];
                end
            end else begin : g_pad
                always_ff @(posedge i_clk) begin
                    r_tv[0][gj]  <= 1'b0;
                    r_tid[0][gj] <= '0;
                end
            end
        end
        for (gl = 1; gl <= SLOT_LOG; gl++) begin : g_lvl
            for (gj = 0; gj < (SLOT_POW >> gl); gj++) begin : g_node
                logic pick_a;
                assign pick_a = r_tv[gl-1][2*gj] &&
                    (!r_tv[gl-1][2*gj+1] || r_tid[gl-1][2*gj] <= r_tid[gl-1][2*gj+1]);
                always_ff @(posedge i_clk) begin
                    r_tv[gl][gj]  <= r_tv[gl-1][2*gj] || r_tv[gl-1][2*gj+1];
                    r_tid[gl][gj] <= pick_a ? r_tid[gl-1][2*gj] : r_tid[gl-1][2*gj+1];
                end
            end
        end
    endgenerate

    assign exec_inc = r_exec_cnt + 32'd1;

    always_comb begin
        n_out      = '0;
        n_exec_cnt = r_exec_cnt;
        n_target   = r_target;
        n_limited  = r_limited;
        n_depth    = r_depth;
        case (r_item.cmd)
            CMD_SET: begin
                if (free_ok) begin
                    n_out.new_id = r_next_ident;
                end else begin
                    n_out.full_res = 1'b1;
                end
            end
            CMD_REMOVE: begin
                n_out.found = rm_ok;
            end
            CMD_RUN: begin
                n_limited = 1'b0;
            end
            CMD_RUN_FOR: begin
                n_target  = r_exec_cnt + r_item.count;
                n_limited = 1'b1;
            end
            CMD_STEP_OVER: begin
                n_limited = 1'b1;
                n_depth   = 16'd0;
            end
            CMD_STEP_OUT: begin
                n_limited = 1'b1;
                n_depth   = 16'd1;
            end
            CMD_PRE_INSTR: begin
                n_out.hit    = r_tv[SLOT_LOG][0];
                n_out.hit_id = r_tv[SLOT_LOG][0] ? r_tid[SLOT_LOG][0] : 16'd0;
            end
            CMD_POST_INSTR: begin
                n_exec_cnt = exec_inc;
                if (r_limited && (exec_inc == r_target || r_depth == 16'd0)) begin
                    n_limited  = 1'b0;
                    n_out.stop = 1'b1;
                end
            end
            CMD_SUB_ENTER: begin
                n_depth = r_depth + 16'd1;
            end
            CMD_SUB_EXIT: begin
                n_depth = r_depth - 16'd1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_item.cmd == CMD_SET && free_ok) begin
            r_slot_addr[free_idx]  <= r_item.address;
            r_slot_ident[free_idx] <= r_next_ident;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_next_ident <= '0;
            r_exec_cnt   <= '0;
            r_target     <= '0;
            r_limited    <= 1'b0;
            r_depth      <= '0;
        end else if (i_cmd.load) begin
            r_exec_cnt <= n_exec_cnt;
            r_target   <= n_target;
            r_limited  <= n_limited;
            r_depth    <= n_depth;
            if (r_item.cmd == CMD_SET && free_ok) begin
                r_slot_valid[free_idx] <= 1'b1;
                r_next_ident           <= r_next_ident + 16'd1;
            end
            if (r_item.cmd == CMD_REMOVE && rm_ok) begin
                r_slot_valid[rm_idx] <= 1'b0;
            end
        end
    end

    assign o_status.is_pre = (r_item.cmd == CMD_PRE_INSTR);
    assign o_out_item      = r_out;

endmodule

// File: hw/rtl/debug_breakpoint_step_unit.sv
// ----------------------------------------------------------------------------
// debug_breakpoint_step_unit
// breakpoint table with lowest-id lookup and run control, one command per item
// ----------------------------------------------------------------------------
// all commands but pre-instruction: the item is registered on accept, then the
//   result is registered from it once the output is free; pre-instruction items
//   first pass the leaf level and each level of the registered lowest-id tree,
//   one level per cycle; no new item is taken before the current result loads;
//   the next item is taken the cycle after that and waits while a result is stalled
// reset: synchronous, active low; clears slot valid bits, the next id, counters and mode
// ----------------------------------------------------------------------------
module debug_breakpoint_step_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dbgbp_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dbgbp_pkg::t_out_item o_out_item
);
    import dbgbp_pkg::*;

    t_ctl_cmd    ctl_cmd;
    t_ctl_status ctl_status;

    dbgbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (ctl_status),
        .o_cmd       (ctl_cmd)
    );

    dbgbp_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item),
        .i_cmd      (ctl_cmd),
        .o_status   (ctl_status)
    );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the breakpoint table and run-control unit
// ----------------------------------------------------------------------------
// Commands go in from a queue through a clocked driver. A clocked monitor takes
// each result and compares every field with a local model of the breakpoint
// table, the instruction counter, the limited-run mode and the call depth.
// A short directed opening is followed by random command sequences under three
// idling patterns.
// ----------------------------------------------------------------------------
module tb;
    import dbgbp_pkg::*;

    localparam int          CYCLE_LIMIT    = 200_000;
    localparam int          DRAIN_CYCLES   = 12;
    localparam logic [3:0]  CMD_SPARE_LAST = 4'd15;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    debug_breakpoint_step_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // local model of the unit
    logic        bp_live [BREAKPOINT_SLOTS];
    logic [15:0] bp_pc   [BREAKPOINT_SLOTS];
    logic [15:0] bp_tag  [BREAKPOINT_SLOTS];
    logic [15:0] tag_next;
    logic [31:0] retired;
    logic [31:0] retire_goal;
    logic        bounded_run;
    logic [15:0] nest_depth;

    t_in_item    pending_cmds [$];
    t_out_item   expected_results [$];
    t_out_item   want;
    logic [15:0] hot_pc [8];

    int sender_idle_pct   = 19;
    int receiver_idle_pct = 65;
    int items_queued      = 0;
    int items_accepted    = 0;
    int results_checked   = 0;
    int hits_seen         = 0;
    int stops_seen        = 0;
    int refusals_seen     = 0;
    int mismatches        = 0;
    int cycle_count       = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic apply_command(input t_in_item it);
        t_out_item res;
        int        sel;
        int        s;
        res = '0;
        sel = -1;
        case (it.cmd)
            CMD_SET: begin
                for (s = 0; s < BREAKPOINT_SLOTS; s++)
                    if (!bp_live[s] && sel < 0) sel = s;
                if (sel < 0) begin
                    res.full_res = 1'b1;
                end else begin
                    bp_live[sel] = 1'b1;
                    bp_pc[sel]   = it.address;
                    bp_tag[sel]  = tag_next;
                    res.new_id   = tag_next;
                    tag_next     = tag_next + 16'd1;
                end
            end
            CMD_REMOVE: begin
                for (s = 0; s < BREAKPOINT_SLOTS; s++)
                    if (bp_live[s] && bp_tag[s] == it.bp_id && sel < 0) sel = s;
                if (sel >= 0) begin
                    bp_live[sel] = 1'b0;
                    res.found    = 1'b1;
                end
            end
            CMD_RUN:       bounded_run = 1'b0;
            CMD_RUN_FOR: begin
                retire_goal = retired + it.count;
                bounded_run = 1'b1;
            end
            CMD_STEP_OVER: begin
                bounded_run = 1'b1;
                nest_depth  = 16'd0;
            end
            CMD_STEP_OUT: begin
                bounded_run = 1'b1;
                nest_depth  = 16'd1;
            end
            CMD_PRE_INSTR: begin
                // strict compare keeps the lowest slot among equal ids
                for (s = 0; s < BREAKPOINT_SLOTS; s++)
                    if (bp_live[s] && bp_pc[s] == it.address)
                        if (sel < 0 || bp_tag[s] < bp_tag[sel]) sel = s;
                if (sel >= 0) begin
                    res.hit    = 1'b1;
                    res.hit_id = bp_tag[sel];
                end
            end
            CMD_POST_INSTR: begin
                retired = retired + 32'd1;
                if (bounded_run && (retired == retire_goal || nest_depth == 16'd0)) begin
                    bounded_run = 1'b0;
                    res.stop    = 1'b1;
                end
            end
            CMD_SUB_ENTER: nest_depth = nest_depth + 16'd1;
            CMD_SUB_EXIT:  nest_depth = nest_depth - 16'd1;
            default: ;
        endcase
        expected_results = {expected_results, res};
    endtask

    task automatic check_field(input string field, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0h, got %0h", field, want_v, got_v);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                apply_command(i_in_item);
                items_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= pending_cmds.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_idle_pct);
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected: %p", o_out_item);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("hit", 16'(want.hit), 16'(o_out_item.hit));
                    check_field("hit_id", want.hit_id, o_out_item.hit_id);
                    check_field("stop", 16'(want.stop), 16'(o_out_item.stop));
                    check_field("new_id", want.new_id, o_out_item.new_id);
                    check_field("found", 16'(want.found), 16'(o_out_item.found));
                    check_field("full_res", 16'(want.full_res), 16'(o_out_item.full_res));
                    results_checked++;
                    if (want.hit) hits_seen++;
                    if (want.stop) stops_seen++;
                    if (want.full_res) refusals_seen++;
                end
            end
        end
    end

    task automatic queue_cmd(input logic [3:0] op, input logic [15:0] pc,
                             input logic [15:0] tag, input logic [31:0] n);
        t_in_item it;
        it.cmd     = op;
        it.address = pc;
        it.bp_id   = tag;
        it.count   = n;
        pending_cmds = {pending_cmds, it};
        items_queued++;
    endtask

    task automatic queue_op(input logic [3:0] op);
        queue_cmd(op, 16'($urandom), 16'($urandom), $urandom);
    endtask

    function automatic logic [15:0] pick_pc();
        if ($urandom_range(9) < 7) return hot_pc[$urandom_range(7)];
        return 16'($urandom);
    endfunction

    // mostly ids that are live in the table, otherwise anything
    function automatic logic [15:0] pick_tag();
        int live_idx [$];
        int s;
        for (s = 0; s < BREAKPOINT_SLOTS; s++)
            if (bp_live[s]) live_idx = {live_idx, s};
        if (live_idx.size() != 0 && $urandom_range(9) < 8)
            return bp_tag[live_idx[$urandom_range(live_idx.size() - 1)]];
        return 16'($urandom);
    endfunction

    task automatic queue_event();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)      queue_op(CMD_POST_INSTR);
        else if (roll < 75) queue_cmd(CMD_PRE_INSTR, pick_pc(), 16'($urandom), $urandom);
        else if (roll < 87) queue_op(CMD_SUB_ENTER);
        else                queue_op(CMD_SUB_EXIT);
    endtask

    task automatic queue_scenario();
        int kind;
        int len;
        int k;
        kind = $urandom_range(9);
        if (kind <= 2) begin
            // table traffic
            len = $urandom_range(8, 3);
            for (k = 0; k < len; k++) begin
                case ($urandom_range(7))
                    0, 1, 2: queue_cmd(CMD_SET, pick_pc(), 16'($urandom), $urandom);
                    3, 4, 5: queue_cmd(CMD_REMOVE, 16'($urandom), pick_tag(), $urandom);
                    default: queue_cmd(CMD_PRE_INSTR, pick_pc(), 16'($urandom), $urandom);
                endcase
            end
        end else if (kind <= 4) begin
            // depth zero stops at once, so usually step in first
            if ($urandom_range(3) != 0) queue_op(CMD_SUB_ENTER);
            queue_cmd(CMD_RUN_FOR, 16'($urandom), 16'($urandom),
                      ($urandom_range(4) == 0) ? $urandom : $urandom_range(6));
            len = $urandom_range(8, 1);
            for (k = 0; k < len; k++) queue_event();
        end else if (kind <= 6) begin
            queue_op(CMD_STEP_OUT);
            len = $urandom_range(6, 1);
            for (k = 0; k < len; k++) queue_event();
            if ($urandom_range(1)) begin
                queue_op(CMD_SUB_EXIT);
                queue_op(CMD_POST_INSTR);
            end
        end else if (kind == 7) begin
            queue_op(CMD_STEP_OVER);
            len = $urandom_range(4, 1);
            for (k = 0; k < len; k++) queue_event();
        end else if (kind == 8) begin
            queue_op(CMD_RUN);
            len = $urandom_range(4, 1);
            for (k = 0; k < len; k++) queue_event();
        end else begin
            // noise, spare codes included
            len = $urandom_range(4, 1);
            for (k = 0; k < len; k++)
                queue_cmd(4'($urandom_range(CMD_SPARE_LAST)), 16'($urandom),
                          16'($urandom), $urandom);
        end
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_random(input int n_items, input int snd_pct, input int rcv_pct);
        int first;
        sender_idle_pct   = snd_pct;
        receiver_idle_pct = rcv_pct;
        first = items_queued;
        while (items_queued - first < n_items) begin
            @(negedge i_clk);
            if (pending_cmds.size() < 3) queue_scenario();
        end
        wait_drained();
    endtask

    initial begin
        for (int s = 0; s < BREAKPOINT_SLOTS; s++) begin
            bp_live[s] = 1'b0;
            bp_pc[s]   = '0;
            bp_tag[s]  = '0;
        end
        tag_next    = '0;
        retired     = '0;
        retire_goal = '0;
        bounded_run = 1'b0;
        nest_depth  = '0;
        hot_pc[0] = 16'h0000;
        hot_pc[1] = 16'hFFFF;
        for (int k = 2; k < 8; k++) hot_pc[k] = 16'($urandom);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening
        queue_cmd(CMD_PRE_INSTR, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
        queue_cmd(CMD_SET, 16'hFFFF, 16'h0000, 32'h0000_0000);
        queue_cmd(CMD_SET, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
        queue_cmd(CMD_SET, 16'hFFFF, 16'h0000, 32'h0000_0000);
        queue_cmd(CMD_PRE_INSTR, 16'hFFFF, 16'h0000, 32'h0000_0000);
        queue_cmd(CMD_REMOVE, 16'h0000, 16'h0000, 32'h0000_0000);
        queue_cmd(CMD_PRE_INSTR, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_cmd(CMD_REMOVE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        queue_cmd(CMD_REMOVE, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
        queue_cmd(CMD_RUN_FOR, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
        queue_op(CMD_SUB_ENTER);
        queue_op(CMD_POST_INSTR);
        queue_op(CMD_RUN);
        queue_op(CMD_SUB_EXIT);
        queue_op(CMD_POST_INSTR);
        queue_op(CMD_STEP_OUT);
        queue_op(CMD_POST_INSTR);
        queue_op(CMD_SUB_EXIT);
        queue_op(CMD_POST_INSTR);
        queue_op(CMD_STEP_OVER);
        queue_op(CMD_POST_INSTR);
        queue_op(CMD_SUB_EXIT);
        queue_cmd(CMD_RUN_FOR, 16'hFFFF, 16'hFFFF, 32'h0000_0002);
        queue_op(CMD_POST_INSTR);
        queue_op(CMD_POST_INSTR);
        queue_cmd(CMD_SPARE_LAST, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        wait_drained();

        run_random(470, 19, 65);
        run_random(470, 65, 19);
        run_random(460, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d items in, %0d results checked, %0d hits, %0d stops, %0d refused",
                 items_accepted, results_checked, hits_seen, stops_seen, refusals_seen);
        $display("tb: directed opening and three idling patterns, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/dbgbp_pkg.sv
hw/rtl/dbgbp_ctrl.sv
hw/rtl/dbgbp_dp.sv
hw/rtl/debug_breakpoint_step_unit.sv
tb/sv/tb.sv
